/* hdl/block_buffer_cache_lru_unit_assert.svh */
// Assertion macros shared by the buffer cache modules
`ifndef BLOCK_BUFFER_CACHE_LRU_UNIT_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bbc_pkg.sv */
// Types, codes and sizes shared by the buffer cache modules
`default_nettype none

package bbc_pkg;

  localparam int NUM_BUFS = 8;
  localparam int SLOT_W   = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
  localparam int MAX_OUT  = 17;
  localparam int CNT_W    = $clog2(MAX_OUT + 1);

  // request codes
  localparam logic [2:0] REQ_LOOKUP  = 3'd0;
  localparam logic [2:0] REQ_RELEASE = 3'd1;
  localparam logic [2:0] REQ_ALLOC   = 3'd2;
  localparam logic [2:0] REQ_RDERR   = 3'd3;
  localparam logic [2:0] REQ_DROP    = 3'd4;
  localparam logic [2:0] REQ_SYNC    = 3'd5;

  // result command codes
  localparam logic [1:0] CMD_DONE  = 2'd0;
  localparam logic [1:0] CMD_WB    = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  // completion status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BUSY   = 2'd2;

  typedef logic [2:0] buf_slot_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] dev;
    logic [15:0] blk;
    logic        rewrite;
    logic [2:0]  slot;
    logic [1:0]  dirty_mode;
  } req_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  status;
    buf_slot_t   buf_slot;
    logic [15:0] cmd_dev;
    logic [15:0] cmd_blk;
    logic        hit;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    SEL_WB,
    SEL_READ,
    SEL_FLUSH,
    SEL_DONE
  } res_sel_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLAIM,
    OP_RELEASE,
    OP_RDERR,
    OP_SCRUB
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     idx_inc;
    logic     vic_track;
    logic     hit_latch;
    logic     idx_to_vic;
    logic     emit;
    res_sel_e sel;
    op_e      op;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       rewrite;
    logic       slot_ok;
    logic       match;
    logic       sweep_hit;
    logic       vic_wb;
    logic       rel_wb;
    logic       last_idx;
    logic       vic_found;
    logic       cap_ok;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

/* hdl/bbc_ctrl.sv */
// Request sequencer for the buffer cache
`default_nettype none
`include "block_buffer_cache_lru_unit_assert.svh"

module bbc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bbc_pkg::stat_t st_i,
  output bbc_pkg::ctl_t      ctl_o
);
  import bbc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_PICK   = 4'd3;
  localparam logic [3:0] S_VWB    = 4'd4;
  localparam logic [3:0] S_CLAIM  = 4'd5;
  localparam logic [3:0] S_READ   = 4'd6;
  localparam logic [3:0] S_REL    = 4'd7;
  localparam logic [3:0] S_RELUPD = 4'd8;
  localparam logic [3:0] S_RDERR  = 4'd9;
  localparam logic [3:0] S_SWEEP  = 4'd10;
  localparam logic [3:0] S_SWB    = 4'd11;
  localparam logic [3:0] S_SFL    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.sel  = SEL_DONE;
    ctl_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (st_i.req_type)
          REQ_LOOKUP, REQ_ALLOC: state_d = S_SCAN;
          REQ_RELEASE:           state_d = st_i.slot_ok ? S_REL : S_DONE;
          REQ_RDERR:             state_d = st_i.slot_ok ? S_RDERR : S_DONE;
          REQ_DROP, REQ_SYNC:    state_d = S_SWEEP;
          default:               state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (st_i.match) begin
          ctl_o.hit_latch = 1'b1;
          state_d         = S_DONE;
        end else begin
          ctl_o.vic_track = 1'b1;
          if (st_i.last_idx) begin
            state_d = S_PICK;
          end else begin
            ctl_o.idx_inc = 1'b1;
          end
        end
      end
      S_PICK: begin
        if (st_i.vic_found) begin
          ctl_o.idx_to_vic = 1'b1;
          state_d          = S_VWB;
        end else begin
          state_d = S_DONE;
        end
      end
      S_VWB: begin
        if (st_i.vic_wb && st_i.cap_ok) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_WB;
          if (st_i.out_free) state_d = S_CLAIM;
        end else begin
          state_d = S_CLAIM;
        end
      end
      S_CLAIM: begin
        ctl_o.op = OP_CLAIM;
        state_d  = (st_i.req_type == REQ_LOOKUP && !st_i.rewrite) ? S_READ : S_DONE;
      end
      S_READ: begin
        if (st_i.cap_ok) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_READ;
          if (st_i.out_free) state_d = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REL: begin
        if (st_i.rel_wb && st_i.cap_ok) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_WB;
          if (st_i.out_free) state_d = S_RELUPD;
        end else begin
          state_d = S_RELUPD;
        end
      end
      S_RELUPD: begin
        ctl_o.op = OP_RELEASE;
        state_d  = S_DONE;
      end
      S_RDERR: begin
        ctl_o.op = OP_RDERR;
        state_d  = S_DONE;
      end
      S_SWEEP: begin
        if (st_i.sweep_hit) begin
          state_d = S_SWB;
        end else begin
          ctl_o.op = OP_SCRUB;
          if (st_i.last_idx) begin
            state_d = S_DONE;
          end else begin
            ctl_o.idx_inc = 1'b1;
          end
        end
      end
      S_SWB: begin
        if (st_i.cap_ok) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_WB;
          if (st_i.out_free) state_d = S_SFL;
        end else begin
          state_d = S_SFL;
        end
      end
      S_SFL: begin
        if (st_i.cap_ok) begin
          ctl_o.emit = 1'b1;
          ctl_o.sel  = SEL_FLUSH;
        end
        if (!st_i.cap_ok || st_i.out_free) begin
          ctl_o.op = OP_SCRUB;
          if (st_i.last_idx) begin
            state_d = S_DONE;
          end else begin
            ctl_o.idx_inc = 1'b1;
            state_d       = S_SWEEP;
          end
        end
      end
      S_DONE: begin
        ctl_o.emit = 1'b1;
        ctl_o.sel  = SEL_DONE;
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BBC_ASSERT_NOW(a_idle_no_emit, state_q == S_IDLE, !ctl_o.emit, "emit while idle")
  `BBC_ASSERT_NOW(a_no_idx_wrap, ctl_o.idx_inc, !st_i.last_idx, "slot index wraps")
  `BBC_ASSERT_NEXT(a_hit_to_done, state_q == S_SCAN && st_i.match, state_q == S_DONE,
    "hit did not go to completion")

endmodule

`default_nettype wire

/* hdl/bbc_dp.sv */
// Slot tables, victim tracker and result register of the buffer cache
`default_nettype none
`include "block_buffer_cache_lru_unit_assert.svh"

module bbc_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bbc_pkg::req_t in_req_i,
  input  wire bbc_pkg::ctl_t ctl_i,
  output bbc_pkg::stat_t     st_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output bbc_pkg::res_t      out_res_o
);
  import bbc_pkg::*;

  // per-slot state
  logic [NUM_BUFS-1:0] valid_q, valid_d, dirty_q, dirty_d, busy_q, busy_d;
  logic [15:0] dev_q [NUM_BUFS];
  logic [15:0] dev_d [NUM_BUFS];
  logic [15:0] blk_q [NUM_BUFS];
  logic [15:0] blk_d [NUM_BUFS];
  logic [15:0] stamp_q [NUM_BUFS];
  logic [15:0] stamp_d [NUM_BUFS];
  logic [15:0] clock_q, clock_d;

  // request context
  req_t              req_q, req_d;
  logic [SLOT_W-1:0] idx_q, idx_d, vic_idx_q, vic_idx_d;
  logic              vic_found_q, vic_found_d;
  logic [15:0]       best_q, best_d;
  logic              hit_q, hit_d, hit_busy_q, hit_busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // result register
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d, res;

  logic        cur_valid, cur_dirty, cur_busy;
  logic [15:0] cur_dev, cur_blk, cur_stamp, age, clock_inc;
  logic        out_free, fire, scrub_match, pick;

  assign cur_valid = valid_q[idx_q];
  assign cur_dirty = dirty_q[idx_q];
  assign cur_busy  = busy_q[idx_q];
  assign cur_dev   = dev_q[idx_q];
  assign cur_blk   = blk_q[idx_q];
  assign cur_stamp = stamp_q[idx_q];
  assign age       = clock_q - cur_stamp;
  assign clock_inc = clock_q + 16'd1;

  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = ctl_i.emit && out_free;

  assign scrub_match = cur_valid && (req_q.req_type == REQ_SYNC || cur_dev == req_q.dev);
  assign pick        = !cur_busy && (!vic_found_q || age >= best_q);

  always_comb begin
    st_o.req_type  = req_q.req_type;
    st_o.rewrite   = req_q.rewrite;
    st_o.slot_ok   = int'(req_q.slot) < NUM_BUFS;
    st_o.match     = req_q.req_type == REQ_LOOKUP && cur_valid &&
                     cur_dev == req_q.dev && cur_blk == req_q.blk;
    st_o.sweep_hit = scrub_match && cur_dirty;
    st_o.vic_wb    = cur_valid && cur_dirty;
    st_o.rel_wb    = req_q.dirty_mode[1] && cur_valid;
    st_o.last_idx  = idx_q == SLOT_W'(NUM_BUFS - 1);
    st_o.vic_found = vic_found_q;
    st_o.cap_ok    = cnt_q < CNT_W'(MAX_OUT - 1);
    st_o.out_free  = out_free;
  end

  // request context next state
  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    vic_idx_d   = vic_idx_q;
    vic_found_d = vic_found_q;
    best_d      = best_q;
    hit_d       = hit_q;
    hit_busy_d  = hit_busy_q;
    cnt_d       = fire ? cnt_q + CNT_W'(1) : cnt_q;
    if (ctl_i.load) begin
      req_d       = in_req_i;
      idx_d       = (in_req_i.req_type == REQ_RELEASE || in_req_i.req_type == REQ_RDERR) ?
                    SLOT_W'(in_req_i.slot) : '0;
      vic_idx_d   = '0;
      vic_found_d = 1'b0;
      best_d      = '0;
      hit_d       = 1'b0;
      hit_busy_d  = 1'b0;
      cnt_d       = '0;
    end else begin
      if (ctl_i.vic_track && pick) begin
        vic_found_d = 1'b1;
        vic_idx_d   = idx_q;
        best_d      = age;
      end
      if (ctl_i.hit_latch) begin
        hit_d      = 1'b1;
        hit_busy_d = cur_busy;
      end
      if (ctl_i.idx_to_vic) begin
        idx_d = vic_idx_q;
      end else if (ctl_i.idx_inc) begin
        idx_d = idx_q + SLOT_W'(1);
      end
    end
  end

  // slot table next state, all writes at idx_q
  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    busy_d  = busy_q;
    dev_d   = dev_q;
    blk_d   = blk_q;
    stamp_d = stamp_q;
    clock_d = clock_q;
    if (ctl_i.hit_latch) busy_d[idx_q] = 1'b1;
    case (ctl_i.op)
      OP_CLAIM: begin
        busy_d[idx_q]  = 1'b1;
        dirty_d[idx_q] = 1'b0;
        if (req_q.req_type == REQ_LOOKUP) begin
          valid_d[idx_q] = 1'b1;
          dev_d[idx_q]   = req_q.dev;
          blk_d[idx_q]   = req_q.blk;
        end else begin
          valid_d[idx_q] = 1'b0;
          clock_d        = clock_inc;
          stamp_d[idx_q] = clock_inc;
        end
      end
      OP_RELEASE: begin
        // mode 1 marks dirty, modes 2 and 3 were written back already
        if (req_q.dirty_mode[1]) begin
          dirty_d[idx_q] = 1'b0;
        end else if (req_q.dirty_mode[0]) begin
          dirty_d[idx_q] = 1'b1;
        end
        busy_d[idx_q]  = 1'b0;
        clock_d        = clock_inc;
        stamp_d[idx_q] = clock_inc;
      end
      OP_RDERR: begin
        valid_d[idx_q] = 1'b0;
        dirty_d[idx_q] = 1'b0;
        busy_d[idx_q]  = 1'b0;
      end
      OP_SCRUB: begin
        if (scrub_match) begin
          dirty_d[idx_q] = 1'b0;
          if (req_q.req_type == REQ_DROP) valid_d[idx_q] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // result formatting
  always_comb begin
    res = '0;
    case (ctl_i.sel)
      SEL_WB: begin
        res.cmd      = CMD_WB;
        res.buf_slot = buf_slot_t'(idx_q);
        res.cmd_dev  = cur_dev;
        res.cmd_blk  = cur_blk;
      end
      SEL_READ: begin
        res.cmd      = CMD_READ;
        res.buf_slot = buf_slot_t'(idx_q);
        res.cmd_dev  = req_q.dev;
        res.cmd_blk  = req_q.blk;
      end
      SEL_FLUSH: begin
        res.cmd      = CMD_FLUSH;
        res.buf_slot = buf_slot_t'(idx_q);
        res.cmd_dev  = cur_dev;
      end
      default: begin
        res.cmd  = CMD_DONE;
        res.last = 1'b1;
        res.hit  = hit_q;
        if (hit_q) begin
          res.status = hit_busy_q ? ST_BUSY : ST_OK;
        end else if ((req_q.req_type == REQ_LOOKUP || req_q.req_type == REQ_ALLOC) &&
                     !vic_found_q) begin
          res.status = ST_NOFREE;
        end else begin
          res.status = ST_OK;
        end
        case (req_q.req_type)
          REQ_LOOKUP: begin
            res.buf_slot = (hit_q || vic_found_q) ? buf_slot_t'(idx_q) : '0;
            res.cmd_dev  = req_q.dev;
            res.cmd_blk  = req_q.blk;
          end
          REQ_ALLOC:            res.buf_slot = vic_found_q ? buf_slot_t'(idx_q) : '0;
          REQ_RELEASE, REQ_RDERR: res.buf_slot = req_q.slot;
          default:              res.buf_slot = '0;
        endcase
      end
    endcase
  end

  always_comb begin
    out_d       = fire ? res : out_q;
    out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      dirty_q     <= '0;
      busy_q      <= '0;
      for (int i = 0; i < NUM_BUFS; i++) begin
        dev_q[i]   <= '0;
        blk_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
      clock_q     <= '0;
      req_q       <= '0;
      idx_q       <= '0;
      vic_idx_q   <= '0;
      vic_found_q <= 1'b0;
      best_q      <= '0;
      hit_q       <= 1'b0;
      hit_busy_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      busy_q      <= busy_d;
      dev_q       <= dev_d;
      blk_q       <= blk_d;
      stamp_q     <= stamp_d;
      clock_q     <= clock_d;
      req_q       <= req_d;
      idx_q       <= idx_d;
      vic_idx_q   <= vic_idx_d;
      vic_found_q <= vic_found_d;
      best_q      <= best_d;
      hit_q       <= hit_d;
      hit_busy_q  <= hit_busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `BBC_ASSERT_NEXT(a_clock_hold, !(ctl_i.op == OP_RELEASE || ctl_i.op == OP_CLAIM),
    $stable(clock_q), "stamp clock moved without release or claim")
  `BBC_ASSERT_NEXT(a_hit_locks, ctl_i.hit_latch, busy_q[$past(idx_q)],
    "hit slot not locked")
  `BBC_ASSERT_NOW(a_last_is_done, out_valid_q && out_q.last, out_q.cmd == CMD_DONE,
    "final beat is not a completion")

endmodule

`default_nettype wire

/* hdl/block_buffer_cache_lru_unit.sv */
// Top level of the block buffer cache tag and replacement manager
`default_nettype none

// Tag and policy manager for a fully associative buffer cache of NUM_BUFS
// slots (bbc_pkg). Each request beat produces one or more result beats and
// always ends with a completion beat (cmd 0, last set); write back, read and
// flush commands come before it in the order the slots are visited. Requests
// are handled one at a time: the sequencer walks the slot table through a
// single entry read port, one slot per cycle, except while a sweep issues
// the write back and flush of a dirty slot. The victim is the unlocked slot
// with the largest 16-bit release age, the later slot winning ties. A new
// request beat is taken once the completion has been loaded into the result
// register, even while that beat still waits for out_ready_i. There is no
// clearing pass after reset: all slot state sits in flip-flops cleared by
// rst_ni.
module block_buffer_cache_lru_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bbc_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bbc_pkg::res_t      out_res_o
);
  import bbc_pkg::*;

  ctl_t  ctl;
  stat_t st;

  // sequencer: decides the walk order and when result beats go out
  bbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  // slot tables, victim tracking and result register
  bbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .ctl_i       (ctl),
    .st_o        (st),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

/* tb/block_buffer_cache_lru_unit_tb.sv */
// Self-checking testbench for the buffer cache tag and replacement manager
module block_buffer_cache_lru_unit_tb;
  import bbc_pkg::*;

  // Longest result-side hold; it must outlast the one-deep request
  // pipeline so the block backs up and drops in_ready_o.
  localparam int HOLD_CYCLES    = 300;
  // Cycles with no beat on either side before the run is called hung.
  // The worst legitimate quiet stretch is the long hold plus one request.
  localparam int WATCHDOG_LIMIT = 3000;

  // --------------------------------------------------------------------
  // Predictor and result checker. Holds its own copy of the slot table
  // and the release clock; every accepted request appends the beats it
  // must produce, every accepted result beat is matched against the
  // oldest of them.
  // --------------------------------------------------------------------
  class cache_scoreboard;
    logic        slot_valid [NUM_BUFS];
    logic        slot_dirty [NUM_BUFS];
    logic        slot_busy  [NUM_BUFS];
    logic [15:0] slot_dev   [NUM_BUFS];
    logic [15:0] slot_blk   [NUM_BUFS];
    logic [15:0] slot_stamp [NUM_BUFS];
    logic [15:0] release_clock;
    res_t        due_results [$];
    int          beat_count;
    int          mismatches, n_requests, n_results, n_hits, n_nofree, n_wb, n_flush;

    function new();
      for (int i = 0; i < NUM_BUFS; i++) begin
        slot_valid[i] = 1'b0;
        slot_dirty[i] = 1'b0;
        slot_busy[i]  = 1'b0;
        slot_dev[i]   = '0;
        slot_blk[i]   = '0;
        slot_stamp[i] = '0;
      end
      release_clock = '0;
      mismatches = 0; n_requests = 0; n_results = 0;
      n_hits = 0; n_nofree = 0; n_wb = 0; n_flush = 0;
    endfunction

    // one beat; a request never produces more than MAX_OUT
    function void add_beat(logic [1:0] cmd, logic [1:0] st, int s, logic [15:0] d,
                           logic [15:0] b, logic h, logic l);
      res_t e;
      if (beat_count >= MAX_OUT) return;
      e.cmd      = cmd;
      e.status   = st;
      e.buf_slot = buf_slot_t'(s);
      e.cmd_dev  = d;
      e.cmd_blk  = b;
      e.hit      = h;
      e.last     = l;
      due_results.push_back(e);
      beat_count++;
      if (cmd == CMD_WB) n_wb++;
      if (cmd == CMD_FLUSH) n_flush++;
    endfunction

    // commands always leave room for the completion beat
    function void add_command(logic [1:0] cmd, int s, logic [15:0] d, logic [15:0] b);
      if (beat_count < MAX_OUT - 1) add_beat(cmd, ST_OK, s, d, b, 1'b0, 1'b0);
    endfunction

    // oldest unlocked slot by wrapped age, later slot wins ties
    function int claim_victim();
      int          v;
      logic [15:0] best, age;
      v = -1;
      best = '0;
      for (int i = 0; i < NUM_BUFS; i++) begin
        if (slot_busy[i]) continue;
        age = release_clock - slot_stamp[i];
        if (v < 0 || age >= best) begin
          v = i;
          best = age;
        end
      end
      if (v < 0) return -1;
      slot_busy[v] = 1'b1;
      if (slot_dirty[v] && slot_valid[v]) add_command(CMD_WB, v, slot_dev[v], slot_blk[v]);
      slot_dirty[v] = 1'b0;
      return v;
    endfunction

    function void predict_request(req_t r);
      int v;
      bit found;
      beat_count = 0;
      found = 1'b0;
      n_requests++;
      case (r.req_type)
        REQ_LOOKUP: begin
          for (int i = 0; i < NUM_BUFS && !found; i++) begin
            if (slot_valid[i] && slot_dev[i] == r.dev && slot_blk[i] == r.blk) begin
              found = 1'b1;
              n_hits++;
              if (slot_busy[i]) begin
                add_beat(CMD_DONE, ST_BUSY, i, r.dev, r.blk, 1'b1, 1'b1);
              end else begin
                slot_busy[i] = 1'b1;
                add_beat(CMD_DONE, ST_OK, i, r.dev, r.blk, 1'b1, 1'b1);
              end
            end
          end
          if (!found) begin
            v = claim_victim();
            if (v < 0) begin
              n_nofree++;
              add_beat(CMD_DONE, ST_NOFREE, 0, r.dev, r.blk, 1'b0, 1'b1);
            end else begin
              slot_dev[v]   = r.dev;
              slot_blk[v]   = r.blk;
              slot_valid[v] = 1'b1;
              if (!r.rewrite) add_command(CMD_READ, v, r.dev, r.blk);
              add_beat(CMD_DONE, ST_OK, v, r.dev, r.blk, 1'b0, 1'b1);
            end
          end
        end
        REQ_RELEASE: begin
          if (r.slot < NUM_BUFS) begin
            if (r.dirty_mode != 2'd0) slot_dirty[r.slot] = 1'b1;
            if (r.dirty_mode >= 2'd2) begin
              if (slot_valid[r.slot])
                add_command(CMD_WB, r.slot, slot_dev[r.slot], slot_blk[r.slot]);
              slot_dirty[r.slot] = 1'b0;
            end
            release_clock++;
            slot_stamp[r.slot] = release_clock;
            slot_busy[r.slot]  = 1'b0;
          end
          add_beat(CMD_DONE, ST_OK, r.slot, '0, '0, 1'b0, 1'b1);
        end
        REQ_ALLOC: begin
          v = claim_victim();
          if (v < 0) begin
            n_nofree++;
            add_beat(CMD_DONE, ST_NOFREE, 0, '0, '0, 1'b0, 1'b1);
          end else begin
            slot_valid[v] = 1'b0;
            release_clock++;
            slot_stamp[v] = release_clock;
            add_beat(CMD_DONE, ST_OK, v, '0, '0, 1'b0, 1'b1);
          end
        end
        REQ_RDERR: begin
          if (r.slot < NUM_BUFS) begin
            slot_valid[r.slot] = 1'b0;
            slot_dirty[r.slot] = 1'b0;
            slot_busy[r.slot]  = 1'b0;
          end
          add_beat(CMD_DONE, ST_OK, r.slot, '0, '0, 1'b0, 1'b1);
        end
        REQ_DROP, REQ_SYNC: begin
          for (int i = 0; i < NUM_BUFS; i++) begin
            if (!slot_valid[i]) continue;
            if (r.req_type == REQ_DROP && slot_dev[i] != r.dev) continue;
            if (slot_dirty[i]) begin
              add_command(CMD_WB, i, slot_dev[i], slot_blk[i]);
              slot_dirty[i] = 1'b0;
              add_command(CMD_FLUSH, i, slot_dev[i], '0);
            end
            if (r.req_type == REQ_DROP) slot_valid[i] = 1'b0;
          end
          add_beat(CMD_DONE, ST_OK, 0, '0, '0, 1'b0, 1'b1);
        end
        default: begin
          add_beat(CMD_DONE, ST_OK, 0, '0, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got === want) return;
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endfunction

    function void check_result_beat(res_t got);
      res_t want;
      n_results++;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
        return;
      end
      want = due_results.pop_front();
      check_field("cmd", want.cmd, got.cmd);
      check_field("status", want.status, got.status);
      check_field("buf_slot", want.buf_slot, got.buf_slot);
      check_field("cmd_dev", want.cmd_dev, got.cmd_dev);
      check_field("cmd_blk", want.cmd_blk, got.cmd_blk);
      check_field("hit", want.hit, got.hit);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_res_o;

  block_buffer_cache_lru_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cache_scoreboard sb;

  // idling switches for the two sides and the one-shot long result hold
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          hold_output = 1'b0;
  logic [15:0] dev_pool [4];

  // --------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; a beat is taken at
  // the first rising edge with in_ready_o high. With no gap drawn, valid
  // simply stays up and only the payload changes.
  // --------------------------------------------------------------------
  task automatic drive_req(input req_t r);
    int gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_request(r);
  endtask

  function automatic req_t make_req(logic [2:0] t, logic [15:0] d, logic [15:0] b,
                                    logic rw, logic [2:0] s, logic [1:0] m);
    req_t r;
    r.req_type   = t;
    r.dev        = d;
    r.blk        = b;
    r.rewrite    = rw;
    r.slot       = s;
    r.dirty_mode = m;
    return r;
  endfunction

  // Mostly well-formed traffic: lookups on a small key set so that hits
  // and evictions of dirty slots happen, releases aimed at locked slots,
  // and a thin layer of allocates, read errors, drops, syncs and junk
  // request codes. Unused fields carry random noise.
  function automatic req_t rand_req();
    req_t r;
    int   pick;
    int   locked [$];
    r.dev        = 16'($urandom);
    r.blk        = 16'($urandom);
    r.rewrite    = 1'($urandom);
    r.slot       = 3'($urandom);
    r.dirty_mode = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.req_type = REQ_LOOKUP;
      if ($urandom_range(0, 9) < 8) begin
        r.dev = dev_pool[$urandom_range(0, 3)];
        r.blk = 16'($urandom_range(0, 5));
      end
    end else if (pick < 70) begin
      r.req_type = REQ_RELEASE;
      for (int i = 0; i < NUM_BUFS; i++)
        if (sb.slot_busy[i]) locked.push_back(i);
      if (locked.size() > 0 && $urandom_range(0, 9) < 9)
        r.slot = 3'(locked[$urandom_range(0, locked.size() - 1)]);
    end else if (pick < 80) begin
      r.req_type = REQ_ALLOC;
    end else if (pick < 86) begin
      r.req_type = REQ_RDERR;
    end else if (pick < 91) begin
      r.req_type = REQ_DROP;
      r.dev = dev_pool[$urandom_range(0, 3)];
    end else if (pick < 96) begin
      r.req_type = REQ_SYNC;
    end else begin
      r.req_type = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------
  // Result side. Before every beat it draws a gap with ready low while idling
  // is on; once it is asked for the long hold it keeps ready low for the hold
  // on its own count, so the request side piles up behind it.
  // --------------------------------------------------------------------
  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        gap = recv_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result_beat(out_res_o);
    end
  end

  // Watchdog: any quiet stretch longer than the limit means the block hung.
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog expired after %0d quiet cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------
  initial begin
    sb = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    dev_pool[0] = 16'h0000;
    dev_pool[1] = 16'hffff;
    dev_pool[2] = 16'($urandom);
    dev_pool[3] = 16'($urandom);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening. From reset every age ties at zero, so the first
    // miss lands in slot 7 and the second in slot 6.
    drive_req(make_req(REQ_LOOKUP, 16'h0000, 16'h0000, 1'b0, 3'd0, 2'd0));   // miss + read
    drive_req(make_req(REQ_LOOKUP, 16'hffff, 16'hffff, 1'b1, 3'd7, 2'd3));   // miss, rewrite
    drive_req(make_req(REQ_LOOKUP, 16'h0000, 16'h0000, 1'b0, 3'd0, 2'd0));   // hit on locked slot
    drive_req(make_req(REQ_RELEASE, 16'hffff, 16'hffff, 1'b1, 3'd7, 2'd1));  // mark dirty
    drive_req(make_req(REQ_LOOKUP, 16'h0000, 16'h0000, 1'b1, 3'd0, 2'd0));   // hit, locks again
    drive_req(make_req(REQ_RELEASE, 16'h0000, 16'h0000, 1'b0, 3'd7, 2'd2));  // immediate write back
    drive_req(make_req(REQ_RELEASE, 16'h0000, 16'h0000, 1'b0, 3'd6, 2'd3));  // mode 3 acts as 2
    drive_req(make_req(REQ_RELEASE, 16'h0000, 16'h0000, 1'b0, 3'd5, 2'd1));  // invalid slot, no wb
    drive_req(make_req(REQ_RELEASE, 16'h0000, 16'h0000, 1'b0, 3'd4, 2'd0));  // clean release
    drive_req(make_req(REQ_ALLOC, 16'h1234, 16'h5678, 1'b0, 3'd0, 2'd0));
    drive_req(make_req(REQ_RDERR, 16'h0000, 16'h0000, 1'b0, 3'd0, 2'd0));
    // eight lookup misses; the allocate still locks a slot, so the last finds no free buffer
    for (int i = 0; i < NUM_BUFS; i++)
      drive_req(make_req(REQ_LOOKUP, 16'h00a5, 16'(i), 1'(i), 3'd0, 2'd0));
    drive_req(make_req(REQ_LOOKUP, 16'h5a00, 16'h0001, 1'b0, 3'd0, 2'd0));   // no free buffer
    drive_req(make_req(REQ_ALLOC, 16'h0000, 16'h0000, 1'b0, 3'd0, 2'd0));    // no free buffer
    drive_req(make_req(REQ_RELEASE, 16'h0000, 16'h0000, 1'b0, 3'd3, 2'd1));
    drive_req(make_req(REQ_RELEASE, 16'h0000, 16'h0000, 1'b0, 3'd2, 2'd1));
    drive_req(make_req(REQ_SYNC, 16'h0000, 16'h0000, 1'b0, 3'd0, 2'd0));
    drive_req(make_req(REQ_DROP, 16'h00a5, 16'h0000, 1'b0, 3'd0, 2'd0));
    drive_req(make_req(3'd6, 16'hffff, 16'hffff, 1'b1, 3'd7, 2'd3));         // unknown codes
    drive_req(make_req(3'd7, 16'h0000, 16'h0000, 1'b0, 3'd0, 2'd0));

    // Random traffic, with a stretch of no idling on either side and one
    // long result hold while requests keep coming.
    for (int i = 0; i < 300; i++) begin
      if (i == 100) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      if (i == 160) begin
        send_idle = 1'b1;
        recv_idle = 1'b1;
      end
      if (i == 220) hold_output = 1'b1;
      drive_req(rand_req());
    end

    for (int i = 0; i < 200; i++)
      drive_req(rand_req());

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    // quiet tail: catches stray beats after the last completion
    repeat (30) @(posedge clk_i);

    $display("Run covered %0d requests and %0d result beats: %0d lookup hits, %0d no-free,",
             sb.n_requests, sb.n_results, sb.n_hits, sb.n_nofree);
    $display("%0d write backs, %0d flushes and a %0d-cycle output hold",
             sb.n_wb, sb.n_flush, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/bbc_pkg.sv
hdl/bbc_ctrl.sv
hdl/bbc_dp.sv
hdl/block_buffer_cache_lru_unit.sv
tb/block_buffer_cache_lru_unit_tb.sv
